// ----- rtl/lzt_pkg.sv -----
`timescale 1ns / 1ps

package lzt_pkg;

	// Default depth of the history memory in bytes.
	localparam int LZT_BUF_DEPTH = 4096;

	// Fixed widths of the stream format.
	localparam int LZT_RP_W    = 16;
	localparam int LZT_OADDR_W = 12;

	// Command byte that closes a stream.
	localparam logic [7:0] LZT_END_MARK = 8'hFF;

	// Where the output byte of a step comes from once the history read returns.
	typedef enum logic [1:0] {
		LZT_SRC_DIRECT,
		LZT_SRC_RAM,
		LZT_SRC_FLIP
	} lzt_src_t;

	// Result status codes.
	typedef enum logic [1:0] {
		LZT_ST_OK,
		LZT_ST_KIND,
		LZT_ST_OVERFLOW,
		LZT_ST_RANGE
	} lzt_status_t;

	// Input word.
	typedef struct packed {
		logic       kind;
		logic [7:0] in_byte;
	} lzt_item_t;

	// Output word.
	typedef struct packed {
		logic                   byte_valid;
		logic [7:0]             out_byte;
		logic [LZT_OADDR_W-1:0] out_addr;
		logic                   wants_byte;
		logic                   finished;
		logic [1:0]             status;
	} lzt_result_t;

	// Decoded step handed from the control unit to the output stage.
	typedef struct packed {
		logic                   byte_valid;
		lzt_src_t               src;
		logic [7:0]             direct;
		logic [LZT_OADDR_W-1:0] out_addr;
		logic                   wants_byte;
		logic                   finished;
		lzt_status_t            status;
	} lzt_step_t;

endpackage

// ----- rtl/lz_tile_decompressor.sv -----
`timescale 1ns / 1ps

// A result word is offered in the cycle after its input word is accepted.
// Throughput: one word per cycle unless result_ready holds the output stage,
// set by the single read and single write port of the history memory; a copy
// that reads the byte written just before is served from a forwarding register.
// Reset: arst_n clears the control state and the output stage flags at once; the
// history memory is not cleared and is only read below the write position.
module lz_tile_decompressor #(
	parameter int BUF_DEPTH = lzt_pkg::LZT_BUF_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  lzt_pkg::lzt_item_t   item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output lzt_pkg::lzt_result_t result
);

	localparam int AW = $clog2(BUF_DEPTH);

	logic               accept;
	lzt_pkg::lzt_step_t step;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic [7:0]         ram_rdata;
	logic               fwd_hit;

	lzt_pkg::lzt_step_t step_s1;
	logic [AW-1:0]      wr_addr_s1;
	logic               fwd_s1;
	logic [7:0]         fwd_data_s1;
	logic               wr_pend_q;
	logic               result_valid_q;
	logic [7:0]         src_byte;
	logic [7:0]         value_s1;

	function automatic logic [7:0] flip8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7-i];
		end
		return r;
	endfunction

	assign item_ready   = !result_valid_q || result_ready;
	assign accept       = item_valid && item_ready;
	assign result_valid = result_valid_q;

	lzt_ctrl #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.kind    (item.kind),
		.in_byte (item.in_byte),
		.step    (step),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr)
	);

	// The byte of the word in the output stage is written in the cycle after accept.
	lzt_ram #(
		.WIDTH(8),
		.DEPTH(BUF_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (wr_pend_q),
		.waddr (wr_addr_s1),
		.wdata (value_s1),
		.re    (accept && rd_en),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// A read that meets the pending write of the same entry takes its data here.
	assign fwd_hit = wr_pend_q && rd_en && (rd_addr == wr_addr_s1);

	assign src_byte = fwd_s1 ? fwd_data_s1 : ram_rdata;

	always_comb begin
		case (step_s1.src)
			lzt_pkg::LZT_SRC_RAM:  value_s1 = src_byte;
			lzt_pkg::LZT_SRC_FLIP: value_s1 = flip8(src_byte);
			default:               value_s1 = step_s1.direct;
		endcase
	end

	always_comb begin
		result.byte_valid = step_s1.byte_valid;
		result.out_byte   = value_s1;
		result.out_addr   = step_s1.out_addr;
		result.wants_byte = step_s1.wants_byte;
		result.finished   = step_s1.finished;
		result.status     = step_s1.status;
	end

	// Output stage handshake and the one-cycle write request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			wr_pend_q      <= 1'b0;
		end else begin
			wr_pend_q <= accept && step.byte_valid;
			if (accept) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Output stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			step_s1     <= step;
			wr_addr_s1  <= wr_addr;
			fwd_s1      <= fwd_hit;
			fwd_data_s1 <= value_s1;
		end
	end

endmodule

// ----- rtl/lzt_ram.sv -----
`timescale 1ns / 1ps

module lzt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = lzt_pkg::LZT_BUF_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write and one registered read per cycle; a read of the entry being
	// written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/lzt_ctrl.sv -----
`timescale 1ns / 1ps

module lzt_ctrl #(
	parameter int BUF_DEPTH = lzt_pkg::LZT_BUF_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic                         kind,
	input  logic [7:0]                   in_byte,
	output lzt_pkg::lzt_step_t           step,
	output logic                         rd_en,
	output logic [$clog2(BUF_DEPTH)-1:0] rd_addr,
	output logic [$clog2(BUF_DEPTH)-1:0] wr_addr
);

	localparam int AW   = $clog2(BUF_DEPTH);
	localparam int WP_W = $clog2(BUF_DEPTH + 1);
	localparam int RP_W = lzt_pkg::LZT_RP_W;

	// Command codes in bits 7..5 of a command byte.
	localparam logic [2:0] CMD_LIT  = 3'd0;
	localparam logic [2:0] CMD_FILL = 3'd1;
	localparam logic [2:0] CMD_ALT  = 3'd2;
	localparam logic [2:0] CMD_ZERO = 3'd3;
	localparam logic [2:0] CMD_FWD  = 3'd4;
	localparam logic [2:0] CMD_FLIP = 3'd5;
	localparam logic [2:0] CMD_BACK = 3'd6;
	localparam logic [2:0] CMD_LONG = 3'd7;

	typedef enum logic [2:0] {
		PH_CMD,
		PH_LONG,
		PH_FILL1,
		PH_FILL2,
		PH_OFS1,
		PH_OFS2,
		PH_RUN,
		PH_LIT
	} phase_t;

	phase_t            phase_q, phase_n;
	logic [2:0]        cmd_q, cmd_n;
	logic [10:0]       rr_q, rr_n;
	logic [10:0]       rr_dec;
	logic [7:0]        ff_q, ff_n;
	logic [7:0]        fs_q, fs_n;
	logic [RP_W-1:0]   rp_q, rp_n;
	logic [WP_W-1:0]   wp_q, wp_n;
	logic              kind_ok;
	logic              in_range;
	logic              emit;
	logic              valid;
	logic              fin;
	logic [7:0]        vdir;
	lzt_pkg::lzt_src_t    src;
	lzt_pkg::lzt_status_t st;

	// First phase of a run once its command and count are known.
	function automatic phase_t run_phase(input logic [2:0] cmd);
		phase_t ph;
		case (cmd) inside
			CMD_LIT:           ph = PH_LIT;
			CMD_FILL, CMD_ALT: ph = PH_FILL1;
			CMD_ZERO:          ph = PH_RUN;
			default:           ph = PH_OFS1;
		endcase
		return ph;
	endfunction

	assign kind_ok  = (kind != (phase_q != PH_RUN));
	assign in_range = (rp_q < RP_W'(wp_q));
	assign rd_addr  = AW'(rp_q);
	assign wr_addr  = AW'(wp_q);

	// Decode of one word against the current control state.
	always_comb begin
		phase_n = phase_q;
		cmd_n   = cmd_q;
		rr_n    = rr_q;
		ff_n    = ff_q;
		fs_n    = fs_q;
		rp_n    = rp_q;
		wp_n    = wp_q;
		st      = lzt_pkg::LZT_ST_OK;
		fin     = 1'b0;
		emit    = 1'b0;
		valid   = 1'b0;
		vdir    = 8'h00;
		src     = lzt_pkg::LZT_SRC_DIRECT;
		rd_en   = 1'b0;
		rr_dec  = (rr_q != 11'd0) ? rr_q - 11'd1 : rr_q;
		if (!kind_ok) begin
			st = lzt_pkg::LZT_ST_KIND;
		end else begin
			unique case (phase_q)
				PH_CMD: begin
					if (in_byte == lzt_pkg::LZT_END_MARK) begin
						fin  = 1'b1;
						wp_n = '0;
					end else if (in_byte[7:5] == CMD_LONG) begin
						// A long form may not name the long form again.
						if (in_byte[4:2] == CMD_LONG) begin
							st = lzt_pkg::LZT_ST_RANGE;
						end else begin
							cmd_n   = in_byte[4:2];
							rr_n    = {1'b0, in_byte[1:0], 8'h00};
							phase_n = PH_LONG;
						end
					end else begin
						cmd_n   = in_byte[7:5];
						rr_n    = {6'b0, in_byte[4:0]} + 11'd1;
						phase_n = run_phase(in_byte[7:5]);
					end
				end
				PH_LONG: begin
					rr_n    = {1'b0, rr_q[9:8], in_byte} + 11'd1;
					phase_n = run_phase(cmd_q);
				end
				PH_FILL1: begin
					ff_n    = in_byte;
					phase_n = (cmd_q == CMD_ALT) ? PH_FILL2 : PH_RUN;
				end
				PH_FILL2: begin
					fs_n    = in_byte;
					phase_n = PH_RUN;
				end
				PH_OFS1: begin
					// Absolute offsets take a second byte; relative ones count back.
					if (!in_byte[7]) begin
						rp_n    = {in_byte, 8'h00};
						phase_n = PH_OFS2;
					end else begin
						rp_n    = RP_W'(wp_q) - {9'b0, in_byte[6:0]} - 16'd1;
						phase_n = PH_RUN;
					end
				end
				PH_OFS2: begin
					rp_n    = rp_q | {8'h00, in_byte};
					phase_n = PH_RUN;
				end
				PH_LIT: begin
					emit = 1'b1;
					vdir = in_byte;
				end
				PH_RUN: begin
					emit = 1'b1;
					case (cmd_q) inside
						CMD_FILL: begin
							vdir = ff_q;
						end
						CMD_ALT: begin
							vdir = ff_q;
							ff_n = fs_q;
							fs_n = ff_q;
						end
						CMD_FWD, CMD_FLIP, CMD_BACK: begin
							if (in_range) begin
								rd_en = 1'b1;
								src   = (cmd_q == CMD_FLIP) ? lzt_pkg::LZT_SRC_FLIP
								                            : lzt_pkg::LZT_SRC_RAM;
							end else begin
								st = lzt_pkg::LZT_ST_RANGE;
							end
							rp_n = (cmd_q == CMD_BACK) ? rp_q - 16'd1 : rp_q + 16'd1;
						end
						default: begin
							vdir = 8'h00;
						end
					endcase
				end
				default: begin
					phase_n = PH_CMD;
				end
			endcase

			// Write position and run count for a byte-producing step.
			if (emit) begin
				if (wp_q >= WP_W'(BUF_DEPTH)) begin
					st    = lzt_pkg::LZT_ST_OVERFLOW;
					src   = lzt_pkg::LZT_SRC_DIRECT;
					vdir  = 8'h00;
					rd_en = 1'b0;
				end else begin
					valid = 1'b1;
					wp_n  = wp_q + WP_W'(1);
				end
				rr_n = rr_dec;
				if (rr_dec == 11'd0) begin
					phase_n = PH_CMD;
				end
			end
		end
	end

	always_comb begin
		step.byte_valid = valid;
		step.src        = src;
		step.direct     = vdir;
		step.out_addr   = valid ? lzt_pkg::LZT_OADDR_W'(wp_q) : '0;
		step.wants_byte = (phase_n != PH_RUN);
		step.finished   = fin;
		step.status     = st;
	end

	// Control state advances on every accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CMD;
			cmd_q   <= 3'd0;
			rr_q    <= 11'd0;
			ff_q    <= 8'h00;
			fs_q    <= 8'h00;
			rp_q    <= '0;
			wp_q    <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			cmd_q   <= cmd_n;
			rr_q    <= rr_n;
			ff_q    <= ff_n;
			fs_q    <= fs_n;
			rp_q    <= rp_n;
			wp_q    <= wp_n;
		end
	end

endmodule
